// ===== sv/pei_pkg.sv =====
// pei_pkg: shared types, codes, constant log2 and exp2 tables and saturation helper
// depends on nothing; imported by all particle integrator modules
package pei_pkg;

   localparam int POW_TABLE_ENTRIES = 256;
   localparam int POW_IDX_W = $clog2(POW_TABLE_ENTRIES);
   localparam int POW_N_W = $clog2(POW_TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      CMD_ADD_FORCE = 2'd0,
      CMD_INTEGRATE = 2'd1,
      CMD_LOAD_POS  = 2'd2,
      CMD_LOAD_VEL  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_INV_MASS = 3'd0,
      CSR_DAMPING  = 3'd1,
      CSR_ACCEL_X  = 3'd2,
      CSR_ACCEL_Y  = 3'd3,
      CSR_ACCEL_Z  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_INTEG = 3'd1,
      OP_BAD   = 3'd2,
      OP_LDPOS = 3'd3,
      OP_LDVEL = 3'd4
   } op_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [23:0]        duration;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               bad_step;
   } rsp_type;

   typedef struct packed {
      op_type          op;
      logic [2:0][31:0] vec;
      logic [23:0]     dt;
   } task_type;

   typedef logic [16:0] pow_tab_type [POW_TABLE_ENTRIES];

   function automatic logic [63:0] isqrt64(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] one;
      logic [63:0] xv;
      res = '0;
      one = 64'h1 << 62;
      xv = x;
      while (one > xv) one = one >> 2;
      while (one != 64'd0) begin
         if (xv >= res + one) begin
            xv = xv - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   function automatic pow_tab_type build_log_tab();
      pow_tab_type t;
      logic [63:0] y;
      logic [16:0] l;
      for (int i = 0; i < POW_TABLE_ENTRIES; i++) begin
         y = ((64'(POW_TABLE_ENTRIES) + 64'(i)) << 30) / 64'(POW_TABLE_ENTRIES);
         l = '0;
         for (int b = 0; b < 16; b++) begin
            y = (y * y) >> 30;
            l = {l[15:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
               l[0] = 1'b1;
               y = y >> 1;
            end
         end
         t[i] = l;
      end
      return t;
   endfunction

   function automatic pow_tab_type build_exp_tab();
      pow_tab_type t;
      logic [63:0] c [17];
      logic [63:0] g;
      logic [63:0] acc;
      c[0] = 64'h1 << 31;
      for (int b = 1; b <= 16; b++) c[b] = isqrt64(c[b-1] << 30);
      for (int i = 0; i < POW_TABLE_ENTRIES; i++) begin
         g = (64'(i) << 16) / 64'(POW_TABLE_ENTRIES);
         acc = 64'h1 << 30;
         for (int b = 1; b <= 16; b++) begin
            if (g[16-b]) acc = (acc * c[b]) >> 30;
         end
         t[i] = 17'(acc >> 14);
      end
      return t;
   endfunction

   localparam pow_tab_type LOG_TAB = build_log_tab();
   localparam pow_tab_type EXP_TAB = build_exp_tab();

   function automatic logic signed [31:0] sat32(logic signed [51:0] v);
      logic signed [31:0] r;
      if (v > 52'sd2147483647) r = 32'sh7fffffff;
      else if (v < -52'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== sv/pei_front.sv =====
// pei_front: accepts transactions, classifies commands, holds a two-entry task queue
// depends on pei_pkg
module pei_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pei_pkg::req_type  req_payload,
   output logic              q_valid,
   output pei_pkg::task_type q_head,
   input  logic              q_pop
);
   import pei_pkg::*;

   task_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push_ok;
   logic       pop_ok;
   task_type   entry;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_head   = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   always_comb begin
      entry.vec = {req_payload.vec_z, req_payload.vec_y, req_payload.vec_x};
      entry.dt  = req_payload.duration;
      unique case (req_payload.cmd)
         CMD_ADD_FORCE: entry.op = OP_ADD;
         CMD_INTEGRATE: entry.op = (req_payload.duration == 24'd0) ? OP_BAD : OP_INTEG;
         CMD_LOAD_POS:  entry.op = OP_LDPOS;
         CMD_LOAD_VEL:  entry.op = OP_LDVEL;
         default:       entry.op = OP_ADD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) count_in = count_ff + 2'd1;
      else if (!push_ok && pop_ok) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (pop_ok) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) slot_ff[wr_ptr_ff] <= entry;
   end

endmodule

// ===== sv/pei_back.sv =====
// pei_back: executes tasks with one shared multiplier, holds particle state and registers
// depends on pei_pkg; fed by pei_front
module pei_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pei_pkg::task_type q_head,
   output logic              q_pop,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pei_pkg::rsp_type  rsp_payload
);
   import pei_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_APPLY  = 15'b000000000000010,
      ST_NORM   = 15'b000000000000100,
      ST_LOG    = 15'b000000000001000,
      ST_EMUL   = 15'b000000000010000,
      ST_EXPIDX = 15'b000000000100000,
      ST_EXPF   = 15'b000000001000000,
      ST_VDT    = 15'b000000010000000,
      ST_POS    = 15'b000000100000000,
      ST_ACC    = 15'b000001000000000,
      ST_ADT    = 15'b000010000000000,
      ST_NV     = 15'b000100000000000,
      ST_DAMP   = 15'b001000000000000,
      ST_VEL    = 15'b010000000000000,
      ST_DONE   = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]        inv_mass_ff;
   logic [16:0]        damping_ff;
   logic signed [31:0] accel_ff [3];

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] frc_ff [3];

   op_type                 op_ff;
   logic [2:0][31:0]       vec_ff;
   logic [23:0]            dt_ff;
   logic [1:0]             axis_ff;
   logic [4:0]             s_ff;
   logic [15:0]            mfrac_ff;
   logic [20:0]            a_ff;
   logic [13:0]            k_ff;
   logic [POW_IDX_W-1:0]   j_ff;
   logic [16:0]            f_ff;
   logic signed [31:0]     acc_ff;
   logic signed [31:0]     nv_ff;
   logic signed [65:0]     prod_ff;
   logic                   bad_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;

   logic signed [32:0]     mul_a;
   logic signed [32:0]     mul_b;
   logic signed [49:0]     sh;
   logic [4:0]             norm_shift;
   logic [32:0]            norm_m;
   logic [16+POW_N_W-1:0]  idx_prod;
   logic [16+POW_N_W-1:0]  j_prod;
   logic [28:0]            e_val;
   logic [15:0]            r_val;
   logic                   load_rsp;

   assign sh          = prod_ff[65:16];
   assign q_pop       = (state_ff == ST_IDLE) && q_valid;
   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_pop);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_EMUL: begin
            mul_a = 33'(a_ff);
            mul_b = 33'(dt_ff);
         end
         ST_VDT: begin
            mul_a = 33'(vel_ff[axis_ff]);
            mul_b = 33'(dt_ff);
         end
         ST_POS: begin
            mul_a = 33'(frc_ff[axis_ff]);
            mul_b = 33'(inv_mass_ff);
         end
         ST_ADT: begin
            mul_a = 33'(acc_ff);
            mul_b = 33'(dt_ff);
         end
         ST_DAMP: begin
            mul_a = 33'(nv_ff);
            mul_b = 33'(f_ff);
         end
         default: ;
      endcase
   end

   // damping normalization and table indexes
   always_comb begin
      norm_shift = 5'd16;
      for (int b = 0; b < 16; b++) begin
         if (damping_ff[b]) norm_shift = 5'(16 - b);
      end
      norm_m   = 33'(damping_ff) << norm_shift;
      idx_prod = (16 + POW_N_W)'(mfrac_ff) * (16 + POW_N_W)'(POW_TABLE_ENTRIES);
      e_val    = prod_ff[44:16];
      r_val    = 16'(17'h10000 - 17'(e_val[15:0]));
      j_prod   = (16 + POW_N_W)'(r_val) * (16 + POW_N_W)'(POW_TABLE_ENTRIES);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = (q_head.op == OP_INTEG) ? ST_NORM : ST_APPLY;
         ST_APPLY:  state_in = ST_DONE;
         ST_NORM:   state_in = ST_LOG;
         ST_LOG:    state_in = ST_EMUL;
         ST_EMUL:   state_in = ST_EXPIDX;
         ST_EXPIDX: state_in = ST_EXPF;
         ST_EXPF:   state_in = ST_VDT;
         ST_VDT:    state_in = ST_POS;
         ST_POS:    state_in = ST_ACC;
         ST_ACC:    state_in = ST_ADT;
         ST_ADT:    state_in = ST_NV;
         ST_NV:     state_in = ST_DAMP;
         ST_DAMP:   state_in = ST_VEL;
         ST_VEL:    state_in = (axis_ff == 2'd2) ? ST_DONE : ST_VDT;
         ST_DONE:   if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         inv_mass_ff  <= 32'h0001_0000;
         damping_ff   <= 17'h10000;
         for (int a = 0; a < 3; a++) begin
            accel_ff[a] <= '0;
            pos_ff[a]   <= '0;
            vel_ff[a]   <= '0;
            frc_ff[a]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_pop) rsp_valid_ff <= 1'b0;

         if (csr_write) begin
            case (csr_index)
               CSR_INV_MASS: inv_mass_ff <= csr_wdata;
               CSR_DAMPING:  damping_ff  <= csr_wdata[16:0];
               CSR_ACCEL_X:  accel_ff[0] <= csr_wdata;
               CSR_ACCEL_Y:  accel_ff[1] <= csr_wdata;
               CSR_ACCEL_Z:  accel_ff[2] <= csr_wdata;
               default: ;
            endcase
         end

         case (state_ff)
            ST_APPLY: begin
               for (int a = 0; a < 3; a++) begin
                  case (op_ff)
                     OP_ADD:   frc_ff[a] <= sat32(52'(frc_ff[a]) + 52'($signed(vec_ff[a])));
                     OP_LDPOS: pos_ff[a] <= vec_ff[a];
                     OP_LDVEL: vel_ff[a] <= vec_ff[a];
                     default: ;
                  endcase
               end
            end
            ST_POS: pos_ff[axis_ff] <= sat32(52'(pos_ff[axis_ff]) + 52'(sh));
            ST_VEL: begin
               vel_ff[axis_ff] <= sh[31:0];
               frc_ff[axis_ff] <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            op_ff   <= q_head.op;
            vec_ff  <= q_head.vec;
            dt_ff   <= q_head.dt;
            bad_ff  <= (q_head.op == OP_BAD);
            axis_ff <= 2'd0;
         end
         ST_NORM: begin
            s_ff     <= norm_shift;
            mfrac_ff <= norm_m[15:0];
         end
         ST_LOG: a_ff <= 21'({s_ff, 16'h0000}) - 21'(LOG_TAB[idx_prod[16 +: POW_IDX_W]]);
         ST_EXPIDX: begin
            k_ff <= 14'(e_val[28:16]) + 14'(e_val[15:0] != 16'd0);
            j_ff <= j_prod[16 +: POW_IDX_W];
         end
         ST_EXPF: begin
            if (damping_ff == 17'd0) f_ff <= '0;
            else if (damping_ff[16]) f_ff <= 17'h10000;
            else if (k_ff > 14'd17) f_ff <= '0;
            else f_ff <= EXP_TAB[j_ff] >> k_ff;
         end
         ST_ACC: acc_ff <= sat32(52'(accel_ff[axis_ff]) + 52'(sh));
         ST_NV:  nv_ff  <= sat32(52'(vel_ff[axis_ff]) + 52'(sh));
         ST_VEL: axis_ff <= axis_ff + 2'd1;
         default: ;
      endcase
      if (load_rsp) begin
         rsp_ff.pos_x    <= pos_ff[0];
         rsp_ff.pos_y    <= pos_ff[1];
         rsp_ff.pos_z    <= pos_ff[2];
         rsp_ff.vel_x    <= vel_ff[0];
         rsp_ff.vel_y    <= vel_ff[1];
         rsp_ff.vel_z    <= vel_ff[2];
         rsp_ff.bad_step <= bad_ff;
      end
   end

endmodule

// ===== sv/particle_euler_integrator.sv =====
// particle_euler_integrator: top level, front classifier and task queue plus back executor
// depends on pei_pkg, pei_front, pei_back
//
//  channel  | ports                                  | direction
//  req      | req_push, req_full, req_payload        | in
//  rsp      | rsp_pop, rsp_empty, rsp_payload        | out
//  csr      | csr_write, csr_index, csr_wdata        | in
//
// add force, load position, load velocity and zero-length steps: states idle, apply and done in the back
// integrate: thirteen products through the one shared multiplier
// two transactions queue in the front while the back works; one result waits at the output
// reset is synchronous and clears state, force sum and registers to defaults
module particle_euler_integrator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pei_pkg::req_type req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pei_pkg::rsp_type rsp_payload,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import pei_pkg::*;

   logic     q_valid;
   logic     q_pop;
   task_type q_head;

   pei_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   pei_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("task queue popped while empty");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> q_valid) else $error("accepted transaction lost");

endmodule
